/* rtl/fractional_delay_line_assert.svh */
// assertion macros shared by the fractional delay line modules
// no dependencies; the files that check their own logic include it
`ifndef FRACTIONAL_DELAY_LINE_ASSERT_SVH
`define FRACTIONAL_DELAY_LINE_ASSERT_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define FDL_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("fdl check failed");

// next-cycle implication
`define FDL_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("fdl check failed");

`else

`define FDL_ASSERT_NOW(label, clk, rst, ante, cons)
`define FDL_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

/* rtl/fdl_pkg.sv */
// types and constants shared by the fractional delay line modules
// no dependencies
package fdl_pkg;

   localparam int SAMPLE_WIDTH    = 16;
   localparam int DELAY_WIDTH     = 20;
   localparam int CSR_INDEX_WIDTH = 1;
   localparam int COEF_WIDTH      = 21;
   localparam int ACC_WIDTH       = 24;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_DELAY_FIXED = 1'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_CUBIC_MODE  = 1'd1;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CLAMP,
      ST_POS,
      ST_READ,
      ST_DRAIN,
      ST_COEF,
      ST_MUL,
      ST_ACC,
      ST_FIN
   } fdl_state_type;

   // neighbor of the read position: i0-1, i0, i0+1, i0+2
   typedef enum logic [1:0] {
      NB_YM1,
      NB_Y0,
      NB_Y1,
      NB_Y2
   } nb_sel_type;

   typedef struct packed {
      logic       wr;
      logic       clamp;
      logic       pos;
      logic       rd;
      nb_sel_type sel;
      logic       coef;
      logic       mul;
      logic       acc;
      logic [1:0] step;
      logic       load;
   } fdl_cmd_type;

   typedef struct packed {
      logic cubic;
      logic out_busy;
   } fdl_status_type;

endpackage

/* rtl/fdl_ram.sv */
// generic single-port ram with registered read data
// no dependencies
module fdl_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      rdata_ff <= mem[addr];
   end

   assign rdata = rdata_ff;

endmodule

/* rtl/fdl_ctrl.sv */
// sequencer of the fractional delay line: write, position, reads, multiply steps
// depends on fdl_pkg and fractional_delay_line_assert.svh
`include "fractional_delay_line_assert.svh"

module fdl_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  fdl_pkg::fdl_status_type status,
   output fdl_pkg::fdl_cmd_type    cmd
);

   import fdl_pkg::*;

   fdl_state_type state_ff, state_in;
   logic [1:0]    cnt_ff, cnt_in;
   logic          rd_last;
   logic          step_last;

   assign rd_last   = status.cubic ? (cnt_ff == 2'd3) : (cnt_ff == 2'd1);
   assign step_last = status.cubic ? (cnt_ff == 2'd2) : (cnt_ff == 2'd0);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_CLAMP;
            end
         end
         ST_CLAMP: begin
            state_in = ST_POS;
         end
         ST_POS: begin
            state_in = ST_READ;
            cnt_in   = '0;
         end
         ST_READ: begin
            if (rd_last) begin
               state_in = ST_DRAIN;
            end else begin
               cnt_in = cnt_ff + 2'd1;
            end
         end
         ST_DRAIN: begin
            state_in = ST_COEF;
         end
         ST_COEF: begin
            state_in = ST_MUL;
            cnt_in   = '0;
         end
         ST_MUL: begin
            state_in = ST_ACC;
         end
         ST_ACC: begin
            if (step_last) begin
               state_in = ST_FIN;
            end else begin
               state_in = ST_MUL;
               cnt_in   = cnt_ff + 2'd1;
            end
         end
         ST_FIN: begin
            if (!status.out_busy) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // outputs
   always_comb begin
      cmd       = '0;
      cmd.step  = cnt_ff;
      // linear mode reads only the two middle neighbors
      cmd.sel   = status.cubic ? nb_sel_type'(cnt_ff) : nb_sel_type'(cnt_ff + 2'd1);
      req_stall = 1'b1;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            cmd.wr    = req_valid;
         end
         ST_CLAMP: cmd.clamp = 1'b1;
         ST_POS:   cmd.pos   = 1'b1;
         ST_READ:  cmd.rd    = 1'b1;
         ST_DRAIN: ;
         ST_COEF:  cmd.coef  = 1'b1;
         ST_MUL:   cmd.mul   = 1'b1;
         ST_ACC:   cmd.acc   = 1'b1;
         ST_FIN:   cmd.load  = !status.out_busy;
         default:  ;
      endcase
   end

   `FDL_ASSERT_NEXT(a_wr_starts_item, clock, reset, cmd.wr, state_ff == ST_CLAMP)
   `FDL_ASSERT_NOW(a_port_exclusive, clock, reset, cmd.wr, !cmd.rd && !cmd.load)
   `FDL_ASSERT_NEXT(a_load_ends_item, clock, reset, cmd.load, state_ff == ST_IDLE)

endmodule

/* rtl/fdl_datapath.sv */
// datapath of the fractional delay line: registers, store, address and interpolation math
// depends on fdl_pkg, fdl_ram and fractional_delay_line_assert.svh
`include "fractional_delay_line_assert.svh"

module fdl_datapath #(
   parameter int DEPTH         = 4096,
   parameter int FRACTION_BITS = 8
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic signed [fdl_pkg::SAMPLE_WIDTH-1:0] req_sample_in,
   input  logic                                 csr_write,
   input  logic [fdl_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  logic [fdl_pkg::DELAY_WIDTH-1:0]      csr_wdata,
   input  fdl_pkg::fdl_cmd_type                 cmd,
   output fdl_pkg::fdl_status_type              status,
   input  logic                                 rsp_stall,
   output logic                                 rsp_valid,
   output logic signed [fdl_pkg::SAMPLE_WIDTH-1:0] rsp_delayed_sample
);

   import fdl_pkg::*;

   localparam int AW  = $clog2(DEPTH);
   localparam int CW  = $clog2(DEPTH + 1);
   localparam int PW  = AW + FRACTION_BITS;
   localparam int XW  = ((CW + FRACTION_BITS) > DELAY_WIDTH ?
                         (CW + FRACTION_BITS) : DELAY_WIDTH) + 1;
   localparam int PRW = ACC_WIDTH + FRACTION_BITS + 1;
   localparam int RW  = ACC_WIDTH + 1;

   localparam logic [XW-1:0] MAXD_LIN = XW'(DEPTH - 1) << FRACTION_BITS;
   localparam logic [XW-1:0] MAXD_CUB = XW'(DEPTH - 3) << FRACTION_BITS;
   localparam logic [PW:0]   SPAN     = (PW + 1)'(DEPTH) << FRACTION_BITS;
   localparam logic [AW:0]   DEPTH_X  = (AW + 1)'(DEPTH);

   // configuration
   logic [DELAY_WIDTH-1:0] delay_fixed_ff;
   logic                   cubic_ff;

   // write side
   logic [AW-1:0] wp_ff, wp_in;
   logic [CW-1:0] fill_ff;

   // read position
   logic [PW-1:0]            dly_ff;
   logic [XW-1:0]            dly_x;
   logic [XW-1:0]            maxd;
   logic [AW-1:0]            i0_ff;
   logic [FRACTION_BITS-1:0] t_ff;
   logic [PW:0]              diff;
   logic [PW:0]              pos_wrap;
   logic [PW-1:0]            pos;

   // store access
   logic [AW-1:0]           rd_addr;
   logic [AW:0]             s1, s2;
   logic [AW-1:0]           ram_addr;
   logic [SAMPLE_WIDTH-1:0] ram_rdata;
   logic                    pend_ff;
   nb_sel_type              pend_sel_ff;
   logic                    pend_ok_ff;
   logic signed [SAMPLE_WIDTH-1:0] rd_val;
   logic signed [SAMPLE_WIDTH-1:0] ym1_ff, y0_ff, y1_ff, y2_ff;

   // interpolation
   logic signed [COEF_WIDTH-1:0] ym1_c, y0_c, y1_c, y2_c;
   logic signed [COEF_WIDTH-1:0] a_ff, b_ff, c_ff;
   logic signed [ACC_WIDTH-1:0]  a_ext, b_ext, c_ext;
   logic signed [ACC_WIDTH-1:0]  acc_ff, acc_in, mul_op, addend;
   logic signed [FRACTION_BITS:0] t_s;
   logic signed [PRW-1:0]        prod_ff, prod_in, prod_sh;
   logic signed [RW-1:0]         y0_r, acc_r, res;
   logic signed [SAMPLE_WIDTH-1:0] res_sat;

   // output register
   logic                           rsp_valid_ff;
   logic signed [SAMPLE_WIDTH-1:0] rsp_data_ff;

   assign status.cubic    = cubic_ff;
   assign status.out_busy = rsp_valid_ff && rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         delay_fixed_ff <= '0;
         cubic_ff       <= 1'b0;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_DELAY_FIXED: delay_fixed_ff <= csr_wdata;
            CSR_CUBIC_MODE:  cubic_ff       <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   assign wp_in = (wp_ff == AW'(DEPTH - 1)) ? '0 : wp_ff + AW'(1);

   // entries at or above the fill count were never written and read as zero
   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff   <= '0;
         fill_ff <= '0;
      end else if (cmd.wr) begin
         wp_ff <= wp_in;
         if (fill_ff != CW'(DEPTH)) begin
            fill_ff <= fill_ff + CW'(1);
         end
      end
   end

   assign dly_x = XW'(delay_fixed_ff);
   assign maxd  = cubic_ff ? MAXD_CUB : MAXD_LIN;

   assign diff     = {1'b0, wp_ff, {FRACTION_BITS{1'b0}}} - {1'b0, dly_ff};
   assign pos_wrap = diff + SPAN;
   assign pos      = diff[PW] ? pos_wrap[PW-1:0] : diff[PW-1:0];

   always_ff @(posedge clock) begin
      if (cmd.clamp) begin
         dly_ff <= (dly_x > maxd) ? maxd[PW-1:0] : dly_x[PW-1:0];
      end
      if (cmd.pos) begin
         i0_ff <= pos[PW-1:FRACTION_BITS];
         t_ff  <= pos[FRACTION_BITS-1:0];
      end
   end

   assign s1 = {1'b0, i0_ff} + (AW + 1)'(1);
   assign s2 = {1'b0, i0_ff} + (AW + 1)'(2);

   always_comb begin
      case (cmd.sel)
         NB_YM1:  rd_addr = (i0_ff == '0) ? AW'(DEPTH - 1) : i0_ff - AW'(1);
         NB_Y0:   rd_addr = i0_ff;
         NB_Y1:   rd_addr = (s1 == DEPTH_X) ? '0 : s1[AW-1:0];
         NB_Y2: begin
            if (s2 >= DEPTH_X) begin
               rd_addr = AW'(s2 - DEPTH_X);
            end else begin
               rd_addr = s2[AW-1:0];
            end
         end
         default: rd_addr = i0_ff;
      endcase
   end

   assign ram_addr = cmd.wr ? wp_ff : rd_addr;

   fdl_ram #(
      .WIDTH (SAMPLE_WIDTH),
      .DEPTH (DEPTH)
   ) u_store (
      .clock (clock),
      .we    (cmd.wr),
      .addr  (ram_addr),
      .wdata (req_sample_in),
      .rdata (ram_rdata)
   );

   // read data is registered in the store and arrives in the cycle after the address
   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= 1'b0;
      end else begin
         pend_ff <= cmd.rd;
      end
      pend_sel_ff <= cmd.sel;
      pend_ok_ff  <= CW'(rd_addr) < fill_ff;
   end

   assign rd_val = pend_ok_ff ? $signed(ram_rdata) : '0;

   always_ff @(posedge clock) begin
      if (pend_ff) begin
         case (pend_sel_ff)
            NB_YM1:  ym1_ff <= rd_val;
            NB_Y0:   y0_ff  <= rd_val;
            NB_Y1:   y1_ff  <= rd_val;
            NB_Y2:   y2_ff  <= rd_val;
            default: y0_ff  <= rd_val;
         endcase
      end
   end

   assign ym1_c = COEF_WIDTH'(ym1_ff);
   assign y0_c  = COEF_WIDTH'(y0_ff);
   assign y1_c  = COEF_WIDTH'(y1_ff);
   assign y2_c  = COEF_WIDTH'(y2_ff);

   // doubled catmull-rom coefficients; linear mode keeps y1-y0 in a
   always_ff @(posedge clock) begin
      if (cmd.coef) begin
         if (cubic_ff) begin
            a_ff <= (y0_c <<< 1) + y0_c + y2_c - ym1_c - (y1_c <<< 1) - y1_c;
            b_ff <= (ym1_c <<< 1) - (y0_c <<< 2) - y0_c + (y1_c <<< 2) - y2_c;
            c_ff <= y1_c - ym1_c;
         end else begin
            a_ff <= y1_c - y0_c;
            b_ff <= '0;
            c_ff <= '0;
         end
      end
   end

   assign a_ext = ACC_WIDTH'(a_ff);
   assign b_ext = ACC_WIDTH'(b_ff);
   assign c_ext = ACC_WIDTH'(c_ff);
   assign t_s   = $signed({1'b0, t_ff});

   assign mul_op  = (cmd.step == 2'd0) ? a_ext : acc_ff;
   assign prod_in = PRW'(mul_op) * PRW'(t_s);
   assign prod_sh = prod_ff >>> FRACTION_BITS;

   always_comb begin
      addend = '0;
      if (cubic_ff) begin
         case (cmd.step)
            2'd0:    addend = b_ext;
            2'd1:    addend = c_ext;
            default: addend = '0;
         endcase
      end
   end

   assign acc_in = prod_sh[ACC_WIDTH-1:0] + addend;

   always_ff @(posedge clock) begin
      if (cmd.mul) begin
         prod_ff <= prod_in;
      end
      if (cmd.acc) begin
         acc_ff <= acc_in;
      end
   end

   assign y0_r  = RW'(y0_ff);
   assign acc_r = RW'(acc_ff);
   assign res   = y0_r + (cubic_ff ? (acc_r >>> 1) : acc_r);

   always_comb begin
      if (res > RW'(32767)) begin
         res_sat = 16'sh7fff;
      end else if (res < -RW'(32768)) begin
         res_sat = 16'sh8000;
      end else begin
         res_sat = res[SAMPLE_WIDTH-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
      if (cmd.load) begin
         rsp_data_ff <= res_sat;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_delayed_sample = rsp_data_ff;

   `FDL_ASSERT_NOW(a_fill_bound, clock, reset, 1'b1, fill_ff <= CW'(DEPTH))
   `FDL_ASSERT_NOW(a_no_overwrite, clock, reset, cmd.load, !(rsp_valid_ff && rsp_stall))
   `FDL_ASSERT_NEXT(a_wp_follows_fill, clock, reset, cmd.wr && (fill_ff != CW'(DEPTH)), CW'(wp_ff) == fill_ff || (wp_ff == '0 && fill_ff == CW'(DEPTH)))

endmodule

/* rtl/fractional_delay_line.sv */
// Fractional delay line: each accepted sample is written into a circular store of DEPTH
// entries, then one sample interpolated at the configured delay (FRACTION_BITS fraction bits)
// is returned, linear or Catmull-Rom cubic as csr cubic_mode selects. One transaction in gives
// one transaction out. Each item runs from acceptance through the store reads and the multiply
// steps to the result register, which is loaded once it is no longer stalled; the next item
// is taken the cycle after. The sequence is set by the single-port sample store (one write and
// up to four neighbor reads per item) and by one shared multiplier that runs the three chained
// cubic products. Never-written store entries read as zero, tracked by a fill count, so no
// clearing pass follows reset. Write csr registers only while no transaction is in flight.
// depends on fdl_pkg, fdl_ctrl and fdl_datapath
module fractional_delay_line #(
   parameter int DEPTH         = 4096,
   parameter int FRACTION_BITS = 8
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_valid,
   output logic                                    req_stall,
   input  logic signed [fdl_pkg::SAMPLE_WIDTH-1:0] req_sample_in,
   output logic                                    rsp_valid,
   input  logic                                    rsp_stall,
   output logic signed [fdl_pkg::SAMPLE_WIDTH-1:0] rsp_delayed_sample,
   input  logic                                    csr_write,
   input  logic [fdl_pkg::CSR_INDEX_WIDTH-1:0]     csr_index,
   input  logic [fdl_pkg::DELAY_WIDTH-1:0]         csr_wdata
);

   import fdl_pkg::*;

   fdl_cmd_type    cmd;
   fdl_status_type status;

   fdl_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   fdl_datapath #(
      .DEPTH         (DEPTH),
      .FRACTION_BITS (FRACTION_BITS)
   ) u_datapath (
      .clock              (clock),
      .reset              (reset),
      .req_sample_in      (req_sample_in),
      .csr_write          (csr_write),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .cmd                (cmd),
      .status             (status),
      .rsp_stall          (rsp_stall),
      .rsp_valid          (rsp_valid),
      .rsp_delayed_sample (rsp_delayed_sample)
   );

endmodule
